// ===== design/fcbh_pkg.sv =====
// fcbh_pkg: shared types and constants of the float class and bit-length histogram
// used by fcbh_front, fcbh_back, the top level and the testbench; no dependencies
`timescale 1ns / 1ps

package fcbh_pkg;

	localparam int MAX_FRACTION_BITS = 52;
	localparam int MAX_EXPONENT_BITS = 11;
	localparam int COUNT_WIDTH       = 32;

	// ieee field widths
	localparam int SGL_EXP  = 8;
	localparam int SGL_FRAC = 23;
	localparam int DBL_EXP  = 11;
	localparam int DBL_FRAC = 52;

	// histogram geometry
	localparam int NORM_STRIDE = MAX_EXPONENT_BITS + 1;
	localparam int NORM_DEPTH  = (MAX_FRACTION_BITS + 1) * NORM_STRIDE;
	localparam int DEN_DEPTH   = MAX_FRACTION_BITS + 1;
	localparam int NORM_AW     = $clog2(NORM_DEPTH);
	localparam int DEN_AW      = $clog2(DEN_DEPTH);

	// item field widths
	localparam int VALUE_W = 64;
	localparam int TBL_W   = 2;
	localparam int FLEN_W  = 6;
	localparam int ELEN_W  = 4;

	localparam int S_BITS    = VALUE_W + TBL_W + FLEN_W + ELEN_W;
	localparam int S_TDATA_W = ((S_BITS + 7) / 8) * 8;
	localparam int M_BITS    = 1 + ELEN_W + FLEN_W + 8 * COUNT_WIDTH;
	localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;

	// queue between front and back, result buffer
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DEPTH   = 4;
	localparam int OUT_AW      = $clog2(OUT_DEPTH);
	localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

	typedef enum logic {
		ACT_RECORD = 1'b0,
		ACT_READ   = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		CLS_NORMAL   = 2'd0,
		CLS_DENORMAL = 2'd1,
		CLS_NAN      = 2'd2,
		CLS_INF      = 2'd3
	} class_t;

	typedef enum logic [TBL_W-1:0] {
		TBL_NORM_POS = 2'd0,
		TBL_NORM_NEG = 2'd1,
		TBL_DEN_POS  = 2'd2,
		TBL_DEN_NEG  = 2'd3
	} table_t;

	// classified item handed from front to back
	typedef struct packed {
		action_t             act;
		class_t              cls;
		logic                neg;
		logic [ELEN_W-1:0]   exp_len;
		logic [FLEN_W-1:0]   frac_len;
		table_t              tbl;
		logic [NORM_AW-1:0]  addr;
		logic                bin_ok;
		logic                bin_inc;
	} item_t;

endpackage

// ===== design/fcbh_ram.sv =====
// fcbh_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module fcbh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/fcbh_front.sv =====
// fcbh_front: accepts stream items, classifies the float and forms the bin address,
// and holds classified items in a short queue; depends on fcbh_pkg
`timescale 1ns / 1ps

module fcbh_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           format_select,
	input  logic                           hold,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// value, bin_table, bin_fraction_len, bin_exponent_len
	input  logic [fcbh_pkg::S_TDATA_W-1:0] s_tdata,
	// action
	input  logic [0:0]                     s_tuser,
	output fcbh_pkg::item_t                head,
	output logic                           head_valid,
	input  logic                           head_pop
);
	import fcbh_pkg::*;

	logic [VALUE_W-1:0]  value;
	table_t              bt;
	logic [FLEN_W-1:0]   bf;
	logic [ELEN_W-1:0]   be;
	action_t             act;

	logic [DBL_FRAC-1:0] frac;
	logic [DBL_EXP-1:0]  expo;
	logic                sign;
	logic                exp_ones;
	logic [FLEN_W-1:0]   fw;
	logic [FLEN_W-1:0]   tz;
	logic [FLEN_W-1:0]   flen;
	logic [ELEN_W-1:0]   elen;
	class_t              cls;
	logic                rd_den;
	item_t               new_item;

	item_t               q_item_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] q_wr_q;
	logic [QUEUE_AW-1:0] q_rd_q;
	logic [QUEUE_CW-1:0] q_count_q;
	logic                push;

	assign value = s_tdata[VALUE_W-1:0];
	assign bt    = table_t'(s_tdata[VALUE_W +: TBL_W]);
	assign bf    = s_tdata[VALUE_W+TBL_W +: FLEN_W];
	assign be    = s_tdata[VALUE_W+TBL_W+FLEN_W +: ELEN_W];
	assign act   = action_t'(s_tuser[0]);

	// split the value by format
	always_comb begin
		if (format_select) begin
			frac     = value[DBL_FRAC-1:0];
			expo     = value[DBL_FRAC +: DBL_EXP];
			sign     = value[DBL_FRAC+DBL_EXP];
			exp_ones = &value[DBL_FRAC +: DBL_EXP];
			fw       = FLEN_W'(DBL_FRAC);
		end else begin
			frac     = DBL_FRAC'(value[SGL_FRAC-1:0]);
			expo     = DBL_EXP'(value[SGL_FRAC +: SGL_EXP]);
			sign     = value[SGL_FRAC+SGL_EXP];
			exp_ones = &value[SGL_FRAC +: SGL_EXP];
			fw       = FLEN_W'(SGL_FRAC);
		end
	end

	// highest set exponent bit and lowest set fraction bit
	always_comb begin
		elen = '0;
		for (int i = 0; i < DBL_EXP; i++) begin
			if (expo[i]) begin
				elen = ELEN_W'(i + 1);
			end
		end
		tz = '0;
		for (int i = DBL_FRAC - 1; i >= 0; i--) begin
			if (frac[i]) begin
				tz = FLEN_W'(i);
			end
		end
		flen = (frac == '0) ? '0 : fw - tz;
	end

	always_comb begin
		priority if (expo == '0) begin
			cls = CLS_DENORMAL;
		end else if (exp_ones) begin
			cls = (frac == '0) ? CLS_INF : CLS_NAN;
		end else begin
			cls = CLS_NORMAL;
		end
	end

	assign rd_den = (bt == TBL_DEN_POS) || (bt == TBL_DEN_NEG);

	always_comb begin
		new_item.act = act;
		if (act == ACT_RECORD) begin
			new_item.cls      = cls;
			new_item.neg      = sign;
			new_item.exp_len  = elen;
			new_item.frac_len = flen;
			new_item.tbl      = table_t'({cls == CLS_DENORMAL, sign});
			new_item.addr     = (cls == CLS_DENORMAL) ? NORM_AW'(flen)
				: NORM_AW'(flen) * NORM_AW'(NORM_STRIDE) + NORM_AW'(elen);
			new_item.bin_ok   = 1'b1;
			// a bin outside its table is not incremented
			new_item.bin_inc  = ((cls == CLS_NORMAL) && (flen <= FLEN_W'(MAX_FRACTION_BITS))
				&& (elen <= ELEN_W'(MAX_EXPONENT_BITS)))
				|| ((cls == CLS_DENORMAL) && (flen <= FLEN_W'(MAX_FRACTION_BITS)));
		end else begin
			new_item.cls      = CLS_NORMAL;
			new_item.neg      = 1'b0;
			new_item.exp_len  = '0;
			new_item.frac_len = '0;
			new_item.tbl      = bt;
			new_item.addr     = rd_den ? NORM_AW'(bf)
				: NORM_AW'(bf) * NORM_AW'(NORM_STRIDE) + NORM_AW'(be);
			new_item.bin_ok   = (bf <= FLEN_W'(MAX_FRACTION_BITS))
				&& (rd_den || (be <= ELEN_W'(MAX_EXPONENT_BITS)));
			new_item.bin_inc  = 1'b0;
		end
	end

	// queue towards the back part
	assign s_tready   = !hold && (q_count_q != QUEUE_CW'(QUEUE_DEPTH));
	assign push       = s_tvalid && s_tready;
	assign head_valid = (q_count_q != '0);
	assign head       = q_item_q[q_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q    <= '0;
			q_rd_q    <= '0;
			q_count_q <= '0;
		end else begin
			if (push) begin
				q_wr_q <= q_wr_q + 1'b1;
			end
			if (head_pop) begin
				q_rd_q <= q_rd_q + 1'b1;
			end
			if (push && !head_pop) begin
				q_count_q <= q_count_q + 1'b1;
			end else if (!push && head_pop) begin
				q_count_q <= q_count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_item_q[q_wr_q] <= new_item;
		end
	end

endmodule

// ===== design/fcbh_back.sv =====
// fcbh_back: histogram memories with read-modify-write and forwarding, saturating
// counters and the result buffer; depends on fcbh_pkg and fcbh_ram
`timescale 1ns / 1ps

module fcbh_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fcbh_pkg::item_t                head,
	input  logic                           head_valid,
	output logic                           head_pop,
	output logic                           clearing,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// is_negative, exponent_len, fraction_len, bin_value, total_count, normal_count,
	// denormal_count, positive_count, negative_count, nan_count, infinity_count
	output logic [fcbh_pkg::M_TDATA_W-1:0] m_tdata,
	// class_code
	output logic [1:0]                     m_tuser
);
	import fcbh_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic                   clearing_q;
	logic [NORM_AW-1:0]     clr_q;

	logic                   valid_s1;
	item_t                  item_s1;

	logic [COUNT_WIDTH-1:0] rd_norm_pos;
	logic [COUNT_WIDTH-1:0] rd_norm_neg;
	logic [COUNT_WIDTH-1:0] rd_den_pos;
	logic [COUNT_WIDTH-1:0] rd_den_neg;
	logic [COUNT_WIDTH-1:0] ram_rdata;
	logic [COUNT_WIDTH-1:0] old_bin;
	logic [COUNT_WIDTH-1:0] new_bin;
	logic                   fwd_hit;

	logic                   fwd_valid_q;
	table_t                 fwd_tbl_q;
	logic [NORM_AW-1:0]     fwd_addr_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;

	logic                   bin_we;
	logic [3:0]             ram_we;
	logic [NORM_AW-1:0]     ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;

	logic [COUNT_WIDTH-1:0] total_q, norm_q, den_q, pos_q, negc_q, nan_q, inf_q;
	logic [COUNT_WIDTH-1:0] total_d, norm_d, den_d, pos_d, negc_d, nan_d, inf_d;
	logic [COUNT_WIDTH-1:0] bin_res;
	logic [M_TDATA_W-1:0]   res_data;

	logic [M_TDATA_W-1:0]   out_data_q [OUT_DEPTH];
	class_t                 out_cls_q  [OUT_DEPTH];
	logic [OUT_AW-1:0]      out_wr_q;
	logic [OUT_AW-1:0]      out_rd_q;
	logic [OUT_CW-1:0]      out_count_q;
	logic                   out_pop;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

	assign clearing = clearing_q;

	// pop only when the result buffer has room for everything in flight
	assign head_pop = head_valid && !clearing_q
		&& ((out_count_q + OUT_CW'(valid_s1)) < OUT_CW'(OUT_DEPTH));

	// clearing pass over the memories after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == NORM_AW'(NORM_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= head_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			item_s1 <= head;
		end
	end

	fcbh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NORM_DEPTH)) u_norm_pos (
		.clk   (clk),
		.we    (ram_we[TBL_NORM_POS]),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head.addr),
		.rdata (rd_norm_pos)
	);

	fcbh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NORM_DEPTH)) u_norm_neg (
		.clk   (clk),
		.we    (ram_we[TBL_NORM_NEG]),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head.addr),
		.rdata (rd_norm_neg)
	);

	fcbh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEN_DEPTH)) u_den_pos (
		.clk   (clk),
		.we    (ram_we[TBL_DEN_POS]),
		.waddr (ram_waddr[DEN_AW-1:0]),
		.wdata (ram_wdata),
		.raddr (head.addr[DEN_AW-1:0]),
		.rdata (rd_den_pos)
	);

	fcbh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEN_DEPTH)) u_den_neg (
		.clk   (clk),
		.we    (ram_we[TBL_DEN_NEG]),
		.waddr (ram_waddr[DEN_AW-1:0]),
		.wdata (ram_wdata),
		.raddr (head.addr[DEN_AW-1:0]),
		.rdata (rd_den_neg)
	);

	always_comb begin
		unique case (item_s1.tbl)
			TBL_NORM_POS: ram_rdata = rd_norm_pos;
			TBL_NORM_NEG: ram_rdata = rd_norm_neg;
			TBL_DEN_POS:  ram_rdata = rd_den_pos;
			TBL_DEN_NEG:  ram_rdata = rd_den_neg;
			default:      ram_rdata = '0;
		endcase
	end

	// the write of the previous item lands on the same edge as this item's read
	assign fwd_hit = fwd_valid_q && (fwd_tbl_q == item_s1.tbl) && (fwd_addr_q == item_s1.addr);
	assign old_bin = fwd_hit ? fwd_data_q : ram_rdata;
	assign new_bin = sat_inc(old_bin);
	assign bin_we  = valid_s1 && item_s1.bin_inc;

	always_comb begin
		ram_we = '0;
		if (clearing_q) begin
			ram_we[TBL_NORM_POS] = 1'b1;
			ram_we[TBL_NORM_NEG] = 1'b1;
			ram_we[TBL_DEN_POS]  = clr_q < NORM_AW'(DEN_DEPTH);
			ram_we[TBL_DEN_NEG]  = clr_q < NORM_AW'(DEN_DEPTH);
			ram_waddr            = clr_q;
			ram_wdata            = '0;
		end else begin
			ram_we[item_s1.tbl] = bin_we;
			ram_waddr           = item_s1.addr;
			ram_wdata           = new_bin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (bin_we) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (bin_we) begin
			fwd_tbl_q  <= item_s1.tbl;
			fwd_addr_q <= item_s1.addr;
			fwd_data_q <= new_bin;
		end
	end

	// counters after this transaction
	always_comb begin
		total_d = total_q;
		norm_d  = norm_q;
		den_d   = den_q;
		pos_d   = pos_q;
		negc_d  = negc_q;
		nan_d   = nan_q;
		inf_d   = inf_q;
		if (valid_s1 && (item_s1.act == ACT_RECORD)) begin
			total_d = sat_inc(total_q);
			if (item_s1.cls != CLS_NAN) begin
				if (item_s1.neg) begin
					negc_d = sat_inc(negc_q);
				end else begin
					pos_d = sat_inc(pos_q);
				end
			end
			unique case (item_s1.cls)
				CLS_NORMAL:   norm_d = sat_inc(norm_q);
				CLS_DENORMAL: den_d  = sat_inc(den_q);
				CLS_NAN:      nan_d  = sat_inc(nan_q);
				CLS_INF:      inf_d  = sat_inc(inf_q);
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			norm_q  <= '0;
			den_q   <= '0;
			pos_q   <= '0;
			negc_q  <= '0;
			nan_q   <= '0;
			inf_q   <= '0;
		end else if (valid_s1) begin
			total_q <= total_d;
			norm_q  <= norm_d;
			den_q   <= den_d;
			pos_q   <= pos_d;
			negc_q  <= negc_d;
			nan_q   <= nan_d;
			inf_q   <= inf_d;
		end
	end

	assign bin_res  = ((item_s1.act == ACT_READ) && item_s1.bin_ok) ? old_bin : '0;
	assign res_data = M_TDATA_W'({inf_d, nan_d, negc_d, pos_d, den_d, norm_d, total_d,
		bin_res, item_s1.frac_len, item_s1.exp_len, item_s1.neg});

	// result buffer
	assign out_pop  = m_tvalid && m_tready;
	assign m_tvalid = (out_count_q != '0);
	assign m_tdata  = out_data_q[out_rd_q];
	assign m_tuser  = out_cls_q[out_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q    <= '0;
			out_rd_q    <= '0;
			out_count_q <= '0;
		end else begin
			if (valid_s1) begin
				out_wr_q <= out_wr_q + 1'b1;
			end
			if (out_pop) begin
				out_rd_q <= out_rd_q + 1'b1;
			end
			if (valid_s1 && !out_pop) begin
				out_count_q <= out_count_q + 1'b1;
			end else if (!valid_s1 && out_pop) begin
				out_count_q <= out_count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			out_data_q[out_wr_q] <= res_data;
			out_cls_q[out_wr_q]  <= item_s1.cls;
		end
	end

endmodule

// ===== design/float_class_bit_histogram_core.sv =====
// float_class_bit_histogram_core: top level, format register and the front and back parts
// depends on fcbh_pkg, fcbh_front, fcbh_back
`timescale 1ns / 1ps

// Classifies IEEE single or double values (format_select: 0 single, 1 double), measures
// exponent bit length and significant fraction length, keeps saturating class and sign
// counters and four bin histograms, and answers bin reads. After reset the block runs a
// clearing pass over the histogram memories, during which s_tready is low; configuration
// writes are taken at any time. After that it takes one transaction per cycle while the
// result buffer has room: a record is one read-modify-write of a histogram memory bin,
// a read item one read, with the latest write forwarded, so back-to-back hits on the
// same bin run at full rate. Results are registered into the result buffer after the
// memory read. A four-entry queue between classification and the histogram update and
// a four-entry result buffer let input and output stall independently.
module float_class_bit_histogram_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// value, bin_table, bin_fraction_len, bin_exponent_len
	input  logic [fcbh_pkg::S_TDATA_W-1:0] s_tdata,
	// action
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// is_negative, exponent_len, fraction_len, bin_value, total_count, normal_count,
	// denormal_count, positive_count, negative_count, nan_count, infinity_count
	output logic [fcbh_pkg::M_TDATA_W-1:0] m_tdata,
	// class_code
	output logic [1:0]                     m_tuser
);
	import fcbh_pkg::*;

	logic  format_select_q;
	item_t head;
	logic  head_valid;
	logic  head_pop;
	logic  clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_select_q <= 1'b0;
		end else if (cfg_we) begin
			format_select_q <= cfg_wdata;
		end
	end

	fcbh_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.format_select (format_select_q),
		.hold          (clearing),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.head          (head),
		.head_valid    (head_valid),
		.head_pop      (head_pop)
	);

	fcbh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.clearing   (clearing),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== test/float_class_bit_histogram_core_tb.sv =====
// float_class_bit_histogram_core_tb: self-checking testbench for the float class and histogram core
// holds its own predictor of the block and drives both stream ports; depends on fcbh_pkg and the rtl
`timescale 1ns / 1ps

module float_class_bit_histogram_core_tb;
	import fcbh_pkg::*;

	localparam logic FMT_SINGLE = 1'b0;
	localparam logic FMT_DOUBLE = 1'b1;

	// receiver stall patterns
	localparam int RX_OPEN   = 0;
	localparam int RX_CHOPPY = 1;
	localparam int RX_SLOW   = 2;

	localparam int HOLD_CYCLES   = 80;
	localparam int DRAIN_CYCLES  = 8;
	localparam int WATCHDOG_IDLE = 3000;

	// m_tdata layout, lowest field last
	typedef struct packed {
		logic [31:0] infinities;
		logic [31:0] nans;
		logic [31:0] negatives;
		logic [31:0] positives;
		logic [31:0] denormals;
		logic [31:0] normals;
		logic [31:0] total;
		logic [31:0] bin;
		logic [5:0]  flen;
		logic [3:0]  elen;
		logic        neg;
	} report_word_t;

	typedef struct packed {
		class_t       cls;
		report_word_t word;
	} report_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic                 cfg_wdata = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [0:0]           s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [1:0]           m_tuser;

	float_class_bit_histogram_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic        fmt_double;
	logic [31:0] pos_norm_hist [NORM_DEPTH];
	logic [31:0] neg_norm_hist [NORM_DEPTH];
	logic [31:0] pos_den_hist [DEN_DEPTH];
	logic [31:0] neg_den_hist [DEN_DEPTH];
	logic [31:0] n_total, n_normal, n_denormal, n_pos, n_neg, n_nan, n_inf;

	// last bin that a record landed in, so reads can aim at live bins
	table_t      last_tbl = TBL_NORM_POS;
	logic [5:0]  last_flen = '0;
	logic [3:0]  last_elen = '0;

	report_t     expected_reports [$];
	int          burst_left = 0;
	bit          hold_req = 1'b0;
	int          rx_mode = RX_OPEN;
	int          mode_left = 0;
	int          mismatches = 0;
	int          results_seen = 0;
	int          idle_cycles = 0;
	int          held_stalls = 0;
	int          records_sent = 0;
	int          reads_sent = 0;
	int          nonzero_reads = 0;
	int          class_hits [4] = '{0, 0, 0, 0};

	function automatic logic [31:0] sat_inc(input logic [31:0] c);
		return (c == '1) ? c : c + 32'd1;
	endfunction

	// classify one value or read one bin and advance the shadow counters
	function automatic report_t classify_and_tally(input action_t act, input logic [63:0] v,
			input table_t tbl, input logic [5:0] bf, input logic [3:0] be);
		report_t     r;
		int          ew, fw, i, idx;
		logic [63:0] frac, ex, emask;
		r = '0;
		if (act == ACT_RECORD) begin
			ew = fmt_double ? DBL_EXP : SGL_EXP;
			fw = fmt_double ? DBL_FRAC : SGL_FRAC;
			emask = (64'd1 << ew) - 64'd1;
			frac = v & ((64'd1 << fw) - 64'd1);
			ex = (v >> fw) & emask;
			r.word.neg = v[fw + ew];
			for (i = 0; i < ew; i++)
				if (ex[i]) r.word.elen = 4'(i + 1);
			if (frac != 0) begin
				i = 0;
				while (!frac[i]) i++;
				r.word.flen = 6'(fw - i);
			end
			if (ex == 0)
				r.cls = CLS_DENORMAL;
			else if (ex == emask)
				r.cls = (frac == 0) ? CLS_INF : CLS_NAN;
			else
				r.cls = CLS_NORMAL;
			class_hits[r.cls]++;
			n_total = sat_inc(n_total);
			if (r.cls == CLS_NAN) begin
				n_nan = sat_inc(n_nan);
			end else begin
				if (r.word.neg) n_neg = sat_inc(n_neg);
				else n_pos = sat_inc(n_pos);
				if (r.cls == CLS_INF) begin
					n_inf = sat_inc(n_inf);
				end else if (r.cls == CLS_NORMAL) begin
					n_normal = sat_inc(n_normal);
					idx = r.word.flen * NORM_STRIDE + r.word.elen;
					if (idx < NORM_DEPTH && r.word.elen < NORM_STRIDE) begin
						if (r.word.neg) neg_norm_hist[idx] = sat_inc(neg_norm_hist[idx]);
						else pos_norm_hist[idx] = sat_inc(pos_norm_hist[idx]);
					end
					last_tbl = r.word.neg ? TBL_NORM_NEG : TBL_NORM_POS;
				end else begin
					n_denormal = sat_inc(n_denormal);
					if (r.word.flen < DEN_DEPTH) begin
						if (r.word.neg) neg_den_hist[r.word.flen] = sat_inc(neg_den_hist[r.word.flen]);
						else pos_den_hist[r.word.flen] = sat_inc(pos_den_hist[r.word.flen]);
					end
					last_tbl = r.word.neg ? TBL_DEN_NEG : TBL_DEN_POS;
				end
				last_flen = r.word.flen;
				last_elen = r.word.elen;
			end
		end else begin
			if (tbl == TBL_NORM_POS || tbl == TBL_NORM_NEG) begin
				if (bf <= MAX_FRACTION_BITS && be <= MAX_EXPONENT_BITS) begin
					idx = bf * NORM_STRIDE + be;
					r.word.bin = (tbl == TBL_NORM_NEG) ? neg_norm_hist[idx] : pos_norm_hist[idx];
				end
			end else if (bf <= MAX_FRACTION_BITS) begin
				r.word.bin = (tbl == TBL_DEN_NEG) ? neg_den_hist[bf] : pos_den_hist[bf];
			end
			if (r.word.bin != 0) nonzero_reads++;
		end
		r.word.total = n_total;
		r.word.normals = n_normal;
		r.word.denormals = n_denormal;
		r.word.positives = n_pos;
		r.word.negatives = n_neg;
		r.word.nans = n_nan;
		r.word.infinities = n_inf;
		return r;
	endfunction

	// offer one item, sender idles between bursts
	task automatic send_item(input action_t act, input logic [63:0] v, input table_t tbl,
			input logic [5:0] bf, input logic [3:0] be);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {{(S_TDATA_W - S_BITS){1'b0}}, be, bf, tbl, v};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		if (act == ACT_RECORD) records_sent++;
		else reads_sent++;
		expected_reports.push_back(classify_and_tally(act, v, tbl, bf, be));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_format(input logic f);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= f;
		@(posedge clk);
		cfg_we <= 1'b0;
		fmt_double = f;
	endtask

	task automatic test_single_values();
		send_item(ACT_RECORD, 64'h0000_0000_0000_0000, TBL_NORM_POS, 6'd0, 4'd0);
		send_item(ACT_RECORD, 64'h0000_0000_8000_0000, TBL_NORM_POS, 6'd0, 4'd0);
		send_item(ACT_RECORD, 64'h0000_0000_0000_0001, TBL_NORM_POS, 6'd0, 4'd0);
		// upper half is ignored in single mode
		send_item(ACT_RECORD, 64'hA5A5_5A5A_007F_FFFF, TBL_NORM_POS, 6'd0, 4'd0);
		send_item(ACT_RECORD, 64'h0000_0000_0080_0000, TBL_NORM_POS, 6'd0, 4'd0);
		send_item(ACT_RECORD, 64'h0000_0000_3F80_0000, TBL_NORM_POS, 6'd0, 4'd0);
		send_item(ACT_RECORD, 64'hFFFF_FFFF_7F7F_FFFF, TBL_NORM_POS, 6'd0, 4'd0);
		send_item(ACT_RECORD, 64'h0000_0000_FF80_0000, TBL_NORM_POS, 6'd0, 4'd0);
		send_item(ACT_RECORD, 64'h0000_0000_7F80_0000, TBL_NORM_POS, 6'd0, 4'd0);
		send_item(ACT_RECORD, 64'h0000_0000_7FC0_0000, TBL_NORM_POS, 6'd0, 4'd0);
		// negative nan carries no sign count
		send_item(ACT_RECORD, 64'h0000_0000_FF80_0001, TBL_NORM_POS, 6'd0, 4'd0);
	endtask

	task automatic test_double_values();
		send_item(ACT_RECORD, 64'h0000_0000_0000_0000, TBL_NORM_POS, 6'd0, 4'd0);
		send_item(ACT_RECORD, 64'h800F_FFFF_FFFF_FFFF, TBL_NORM_POS, 6'd0, 4'd0);
		send_item(ACT_RECORD, 64'h3FF0_0000_0000_0000, TBL_NORM_POS, 6'd0, 4'd0);
		send_item(ACT_RECORD, 64'h7FEF_FFFF_FFFF_FFFF, TBL_NORM_POS, 6'd0, 4'd0);
		send_item(ACT_RECORD, 64'h7FF0_0000_0000_0000, TBL_NORM_POS, 6'd0, 4'd0);
		send_item(ACT_RECORD, 64'hFFF8_0000_0000_0001, TBL_NORM_POS, 6'd0, 4'd0);
	endtask

	task automatic test_bin_reads();
		send_item(ACT_READ, '1, TBL_NORM_POS, 6'd0, 4'd7);
		send_item(ACT_READ, '1, TBL_NORM_POS, 6'd52, 4'd11);
		send_item(ACT_READ, '1, TBL_DEN_POS, 6'd0, 4'd0);
		// exponent length is ignored on denormal tables
		send_item(ACT_READ, '1, TBL_DEN_NEG, 6'd52, 4'd15);
		send_item(ACT_READ, '1, TBL_DEN_POS, 6'd23, 4'd3);
		// addresses past the table edge read zero
		send_item(ACT_READ, '1, TBL_NORM_POS, 6'd63, 4'd15);
		send_item(ACT_READ, '1, TBL_NORM_NEG, 6'd5, 4'd12);
		send_item(ACT_READ, '1, TBL_DEN_NEG, 6'd53, 4'd0);
	endtask

	task automatic test_random_traffic(input int count);
		int          n, kind, ew, fw, elen_t, flen_t;
		logic [63:0] ex, frac, emask, v, r64;
		logic        neg;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) < 3) begin
				if ($urandom_range(0, 1))
					send_item(ACT_READ, {$urandom, $urandom}, last_tbl, last_flen, last_elen);
				else
					send_item(ACT_READ, {$urandom, $urandom}, table_t'($urandom_range(0, 3)),
						6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)));
			end else begin
				ew = fmt_double ? DBL_EXP : SGL_EXP;
				fw = fmt_double ? DBL_FRAC : SGL_FRAC;
				emask = (64'd1 << ew) - 64'd1;
				r64 = {$urandom, $urandom};
				// fraction with an exact significant length
				flen_t = $urandom_range(0, fw);
				if (flen_t == 0)
					frac = '0;
				else
					frac = ((r64 << (fw - flen_t)) | (64'd1 << (fw - flen_t)))
						& ((64'd1 << fw) - 64'd1);
				elen_t = $urandom_range(1, ew);
				ex = (64'd1 << (elen_t - 1)) | ({$urandom, $urandom} & ((64'd1 << (elen_t - 1)) - 64'd1));
				neg = 1'($urandom_range(0, 1));
				kind = $urandom_range(0, 9);
				if (kind <= 4) begin
					if (ex == emask) ex[0] = 1'b0;
				end else if (kind <= 6) begin
					ex = '0;
				end else if (kind == 7) begin
					ex = emask;
					frac = '0;
				end else begin
					ex = emask;
					if (frac == 0) frac = 64'd1 << $urandom_range(0, fw - 1);
				end
				if (fmt_double)
					v = {neg, ex[10:0], frac[51:0]};
				else
					v = {$urandom, neg, ex[7:0], frac[22:0]};
				if (kind == 9) v = {$urandom, $urandom};
				send_item(ACT_RECORD, v, table_t'($urandom_range(0, 3)),
					6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)));
			end
		end
	endtask

	// receiver holds off while the sender streams without gaps, so the input must stall
	task automatic test_output_backpressure();
		hold_req = 1'b1;
		burst_left = 1000;
		test_random_traffic(40);
		burst_left = 0;
		while (hold_req) @(posedge clk);
	endtask

	always begin
		@(posedge clk);
		if (hold_req) begin
			m_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_req = 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = $urandom_range(RX_OPEN, RX_SLOW);
				mode_left = $urandom_range(5, 40);
			end
			mode_left--;
			case (rx_mode)
				RX_OPEN: m_tready <= 1'b1;
				RX_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	function automatic void compare_field(input string label, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s of result %0d: expected %0h, got %0h",
					label, results_seen, want, got);
		end
	endfunction

	// result checker and watchdog
	always @(posedge clk) begin
		report_t      want;
		report_word_t got;
		if (hold_req && s_tvalid && !s_tready) held_stalls++;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_IDLE) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				idle_cycles, expected_reports.size());
			$display("float_class_bit_histogram_core verification failed");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing outstanding", results_seen);
			end else begin
				want = expected_reports.pop_front();
				got = m_tdata[$bits(report_word_t)-1:0];
				compare_field("class_code", 64'(want.cls), 64'(m_tuser));
				compare_field("is_negative", 64'(want.word.neg), 64'(got.neg));
				compare_field("exponent_len", 64'(want.word.elen), 64'(got.elen));
				compare_field("fraction_len", 64'(want.word.flen), 64'(got.flen));
				compare_field("bin_value", 64'(want.word.bin), 64'(got.bin));
				compare_field("total_count", 64'(want.word.total), 64'(got.total));
				compare_field("normal_count", 64'(want.word.normals), 64'(got.normals));
				compare_field("denormal_count", 64'(want.word.denormals), 64'(got.denormals));
				compare_field("positive_count", 64'(want.word.positives), 64'(got.positives));
				compare_field("negative_count", 64'(want.word.negatives), 64'(got.negatives));
				compare_field("nan_count", 64'(want.word.nans), 64'(got.nans));
				compare_field("infinity_count", 64'(want.word.infinities),
					64'(got.infinities));
			end
			results_seen++;
		end
	end

	initial begin
		fmt_double = FMT_SINGLE;
		for (int i = 0; i < NORM_DEPTH; i++) begin
			pos_norm_hist[i] = '0;
			neg_norm_hist[i] = '0;
		end
		for (int i = 0; i < DEN_DEPTH; i++) begin
			pos_den_hist[i] = '0;
			neg_den_hist[i] = '0;
		end
		{n_total, n_normal, n_denormal, n_pos, n_neg, n_nan, n_inf} = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		set_format(FMT_SINGLE);
		test_single_values();
		set_format(FMT_DOUBLE);
		test_double_values();
		test_bin_reads();
		test_random_traffic(180);
		set_format(FMT_SINGLE);
		test_random_traffic(140);
		test_output_backpressure();
		set_format(FMT_DOUBLE);
		test_random_traffic(140);
		wait_drained();

		$display("covered %0d records and %0d bin reads (%0d nonzero) in both formats, %0d results",
			records_sent, reads_sent, nonzero_reads, results_seen);
		$display("classes normal %0d, denormal or zero %0d, nan %0d, infinity %0d; %0d held stalls",
			class_hits[CLS_NORMAL], class_hits[CLS_DENORMAL], class_hits[CLS_NAN],
			class_hits[CLS_INF], held_stalls);
		if (mismatches == 0)
			$display("float_class_bit_histogram_core verification clean");
		else
			$display("float_class_bit_histogram_core verification failed");
		$finish;
	end

endmodule

// ===== float_class_bit_histogram_core.f =====
design/fcbh_pkg.sv
design/fcbh_ram.sv
design/fcbh_front.sv
design/fcbh_back.sv
design/float_class_bit_histogram_core.sv
test/float_class_bit_histogram_core_tb.sv
